>>> sv/ktg_pkg.sv
// Package of shared sizes and codes for the keyword trie goto table.
package ktg_pkg;

	localparam int STATE_BITS  = 8;
	localparam int SYMBOL_BITS = 8;
	localparam int MAX_STATES  = 256;
	localparam int SLOT_BITS   = STATE_BITS + SYMBOL_BITS;
	localparam int INDEX_BITS  = 16;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef logic [STATE_BITS-1:0] state_t;
	typedef logic [SLOT_BITS-1:0]  slot_t;
	typedef logic [INDEX_BITS-1:0] index_t;

endpackage

>>> sv/ktg_if.sv
// Request and response channel interfaces of the keyword trie goto table.
interface ktg_req_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] symbol;
	logic [7:0] query_state;
	logic       last_symbol;

	modport source(output valid, opcode, symbol, query_state, last_symbol, input ready);
	modport sink(input valid, opcode, symbol, query_state, last_symbol, output ready);
endinterface

interface ktg_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  next_state;
	logic        fail;
	logic        keyword_done;
	logic [15:0] keyword_index;
	logic        table_full;

	modport source(output valid, next_state, fail, keyword_done, keyword_index, table_full,
		input ready);
	modport sink(input valid, next_state, fail, keyword_done, keyword_index, table_full,
		output ready);
endinterface

>>> sv/ktg_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
module ktg_ram #(
	parameter int AW = 8,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/keyword_trie_goto_table.sv
// Top level of the keyword trie goto table: sequencer, trie state and edge memories.
//
//  channel | role   | carries
//  --------+--------+-----------------------------------------------------------
//  req     | sink   | opcode, symbol, query_state, last_symbol
//  rsp     | source | next_state, fail, keyword_done, keyword_index, table_full
//
// Each request goes through one read of the edge target memory, one read of the
// state key memory at that target, then the decision and any write-back.
// An edge counts as present only when its target is an existing state whose recorded
// parent slot matches, so the edge memory needs no clearing after reset.
// The result register frees the input side; a request waits in its last cycle only
// while an earlier result has not been taken.
module keyword_trie_goto_table (
	input  logic        clk,
	input  logic        arst_n,
	ktg_req_if.sink     req,
	ktg_rsp_if.source   rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EDGE = 2'd1;
	localparam logic [1:0] ST_KEY  = 2'd2;

	logic [1:0]      state_q;
	ktg_pkg::state_t used_q;
	ktg_pkg::state_t cursor_q;
	logic            diverged_q;
	ktg_pkg::index_t seen_q;

	logic            op_q;
	logic            last_q;
	logic            qs_ok_q;
	logic            qs_zero_q;
	ktg_pkg::slot_t  slot_q;
	ktg_pkg::state_t target_q;

	ktg_pkg::slot_t  rd_slot;
	ktg_pkg::slot_t  edge_raddr;
	ktg_pkg::state_t edge_rdata;
	ktg_pkg::slot_t  key_rdata;
	ktg_pkg::state_t new_state;
	logic            hit;
	logic            no_room;
	logic            out_free;
	logic            finish;
	logic            mem_we;

	logic            valid_q;
	ktg_pkg::state_t next_state_q;
	logic            fail_q;
	logic            done_q;
	ktg_pkg::index_t index_q;
	logic            full_q;

	assign req.ready = (state_q == ST_IDLE);
	assign rd_slot = {(req.opcode == ktg_pkg::OP_LOOKUP) ?
		req.query_state[ktg_pkg::STATE_BITS-1:0] : cursor_q,
		req.symbol[ktg_pkg::SYMBOL_BITS-1:0]};
	assign edge_raddr = (state_q == ST_IDLE) ? rd_slot : slot_q;

	assign new_state = used_q + ktg_pkg::state_t'(1);
	assign no_room   = (used_q == ktg_pkg::state_t'(ktg_pkg::MAX_STATES - 1));
	assign out_free  = !valid_q || rsp.ready;
	assign finish    = (state_q == ST_KEY) && out_free;

	always_comb begin
		hit = 1'b0;
		if ((target_q != '0) && (target_q <= used_q) && (key_rdata == slot_q)) begin
			hit = 1'b1;
		end
	end

	assign mem_we = finish && (op_q == ktg_pkg::OP_INSERT) && !(!diverged_q && hit) &&
		!no_room;

	ktg_ram #(.AW(ktg_pkg::SLOT_BITS), .DW(ktg_pkg::STATE_BITS)) u_edge_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_q),
		.wdata (new_state),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	ktg_ram #(.AW(ktg_pkg::STATE_BITS), .DW(ktg_pkg::SLOT_BITS)) u_key_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (new_state),
		.wdata (slot_q),
		.raddr (edge_rdata),
		.rdata (key_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			op_q      <= req.opcode;
			last_q    <= req.last_symbol;
			slot_q    <= rd_slot;
			qs_ok_q   <= ({1'b0, req.query_state} < 9'(ktg_pkg::MAX_STATES));
			qs_zero_q <= (req.query_state == 8'd0);
		end
		if (state_q == ST_EDGE) begin
			target_q <= edge_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			used_q     <= '0;
			cursor_q   <= '0;
			diverged_q <= 1'b0;
			seen_q     <= '0;
			valid_q    <= 1'b0;
		end else begin
			if (rsp.ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_EDGE;
					end
				end
				ST_EDGE: begin
					state_q <= ST_KEY;
				end
				ST_KEY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						valid_q <= 1'b1;
						if (op_q == ktg_pkg::OP_INSERT) begin
							if (!diverged_q && hit) begin
								cursor_q <= target_q;
							end else begin
								diverged_q <= 1'b1;
								if (!no_room) begin
									used_q   <= new_state;
									cursor_q <= new_state;
								end
							end
							if (last_q) begin
								cursor_q   <= '0;
								diverged_q <= 1'b0;
								if (seen_q != '1) begin
									seen_q <= seen_q + ktg_pkg::index_t'(1);
								end
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			next_state_q <= '0;
			fail_q       <= 1'b0;
			done_q       <= 1'b0;
			index_q      <= '0;
			full_q       <= 1'b0;
			if (op_q == ktg_pkg::OP_LOOKUP) begin
				if (qs_ok_q && hit) begin
					next_state_q <= target_q;
				end else begin
					fail_q <= !qs_zero_q;
				end
			end else begin
				if (!diverged_q && hit) begin
					next_state_q <= target_q;
				end else if (no_room) begin
					full_q       <= 1'b1;
					next_state_q <= cursor_q;
				end else begin
					next_state_q <= new_state;
				end
				if (last_q && ((!diverged_q && hit) || !no_room)) begin
					done_q  <= 1'b1;
					index_q <= seen_q;
				end
			end
		end
	end

	assign rsp.valid         = valid_q;
	assign rsp.next_state    = next_state_q;
	assign rsp.fail          = fail_q;
	assign rsp.keyword_done  = done_q;
	assign rsp.keyword_index = index_q;
	assign rsp.table_full    = full_q;

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> used_q >= $past(used_q))
		else $error("State count went backward.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q) |-> $past(state_q == ST_KEY))
		else $error("Result appeared without a finished request.");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> !(done_q && full_q) && !(fail_q && op_q == ktg_pkg::OP_INSERT && done_q))
		else $error("Result flags contradict each other.");

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !no_room && (state_q == ST_KEY))
		else $error("Memory written without a free state.");
`endif

endmodule
